[rtl/windowed_ac_rms_macros.svh]
// Assertion macros used by the port-level checker of windowed_ac_rms.
// No dependencies; included by bare file name.
`ifndef WINDOWED_AC_RMS_MACROS_SVH
`define WINDOWED_AC_RMS_MACROS_SVH

// Same-cycle implication, disabled while the reset expression is low.
`define WAR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("windowed_ac_rms assertion failed");

// Next-cycle implication, disabled while the reset expression is low.
`define WAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("windowed_ac_rms assertion failed");

`endif

[rtl/war_pkg.sv]
// Package for windowed_ac_rms: fixed field widths, register reset value,
// controller state type and the command and status structs. No dependencies.
package war_pkg;

    localparam int SAMPLE_FIELD_W = 12;
    localparam int RMS_W          = 12;
    localparam int WINDOW_REG_W   = 14;
    localparam int MIN_WINDOW     = 2;
    localparam logic [WINDOW_REG_W-1:0] WINDOW_RESET = 14'd5000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_A,
        ST_MUL_A,
        ST_LOAD_B,
        ST_MUL_B,
        ST_SQRT,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accum;
        logic load_a;
        logic step_a;
        logic load_b;
        logic step_b;
        logic step_sqrt;
        logic step_div;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic close;
        logic out_busy;
    } t_status;

endpackage

[rtl/war_ctrl.sv]
// Controller of windowed_ac_rms: state machine and iteration counter that
// sequence the datapath. Depends on war_pkg.
module war_ctrl
    import war_pkg::*;
#(
    parameter int CNT_W = 14,
    parameter int SUM_W = 26
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    localparam int ITER_W = $clog2(SUM_W);

    t_state r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic last_a, last_long;

    assign last_a    = (r_iter == ITER_W'(CNT_W - 1));
    assign last_long = (r_iter == ITER_W'(SUM_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accum = 1'b1;
                    if (i_status.close) n_state = ST_LOAD_A;
                end
            end
            ST_LOAD_A: begin
                o_cmd.load_a = 1'b1;
                n_state      = ST_MUL_A;
            end
            ST_MUL_A: begin
                o_cmd.step_a = 1'b1;
                if (last_a) n_state = ST_LOAD_B;
            end
            ST_LOAD_B: begin
                o_cmd.load_b = 1'b1;
                n_state      = ST_MUL_B;
            end
            ST_MUL_B: begin
                o_cmd.step_b = 1'b1;
                if (last_long) n_state = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.step_sqrt = 1'b1;
                if (last_long) n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.step_div = 1'b1;
                if (last_long) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // Wait here only while the previous result is still unclaimed.
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_iter = (n_state != r_state) ? '0 : r_iter + 1'b1;
    end

endmodule

[rtl/war_dp.sv]
// Datapath of windowed_ac_rms: accumulators, window register, shift-add
// multiplier, digit-by-digit square root, restoring divider and result register.
// Depends on war_pkg.
module war_dp
    import war_pkg::*;
#(
    parameter int MAX_WINDOW = 8192,
    parameter int SB         = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wen,
    input  logic [WINDOW_REG_W-1:0]   i_cfg_wdata,
    input  logic [SAMPLE_FIELD_W-1:0] i_sample,
    input  t_cmd                      i_cmd,
    input  logic                      i_out_ready,
    output t_status                   o_status,
    output logic                      o_out_valid,
    output logic [RMS_W-1:0]          o_rms_value
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SB + CNT_W;
    localparam int SQ_W  = 2 * SB + CNT_W;
    localparam int D_W   = 2 * SUM_W;
    localparam int R_W   = SUM_W;
    localparam int CMP_W = (CNT_W > WINDOW_REG_W) ? CNT_W : WINDOW_REG_W;

    logic [WINDOW_REG_W-1:0] r_window;
    logic [CNT_W-1:0]        r_count;
    logic [SUM_W-1:0]        r_sum;
    logic [SQ_W-1:0]         r_sq;
    logic [D_W-1:0]          r_acc;
    logic [D_W-1:0]          r_mcand;
    logic [SUM_W-1:0]        r_mplier;
    logic [R_W-1:0]          r_root;
    logic [R_W+1:0]          r_srem;
    logic [CNT_W-1:0]        r_drem;
    logic                    r_out_valid;
    logic [RMS_W-1:0]        r_out_data;

    logic [SB-1:0]    samp;
    logic [2*SB-1:0]  samp_sq;
    logic [CNT_W:0]   count_inc;
    logic [CMP_W-1:0] win_ext, max_ext, eff;
    logic [R_W+3:0]   rem_sh, trial;
    logic             sq_take;
    logic [CNT_W:0]   div_sh, div_n;
    logic             div_take;

    assign samp    = i_sample[SB-1:0];
    assign samp_sq = (2 * SB)'(samp) * (2 * SB)'(samp);

    // Window length clamped to the supported range.
    assign win_ext   = CMP_W'(r_window);
    assign max_ext   = CMP_W'(MAX_WINDOW);
    assign eff       = (win_ext < CMP_W'(MIN_WINDOW)) ? CMP_W'(MIN_WINDOW) :
                       (win_ext > max_ext) ? max_ext : win_ext;
    assign count_inc = {1'b0, r_count} + 1'b1;

    assign o_status.close    = ((CMP_W + 1)'(count_inc) >= {1'b0, eff});
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    // One root digit per cycle: two radicand bits enter the remainder.
    assign rem_sh  = {r_srem, r_acc[D_W-1 -: 2]};
    assign trial   = (R_W + 4)'({r_root, 2'b01});
    assign sq_take = (rem_sh >= trial);

    // One quotient bit per cycle; the root register doubles as the quotient.
    assign div_sh   = {r_drem, r_root[R_W-1]};
    assign div_n    = {1'b0, r_count};
    assign div_take = (div_sh >= div_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_count     <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) r_window <= i_cfg_wdata;
            if (i_cmd.accum) begin
                r_count <= count_inc[CNT_W-1:0];
                r_sum   <= r_sum + SUM_W'(samp);
                r_sq    <= r_sq + SQ_W'(samp_sq);
            end else if (i_cmd.emit) begin
                r_count <= '0;
                r_sum   <= '0;
                r_sq    <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) begin
            r_acc    <= '0;
            r_mcand  <= D_W'(r_sq);
            r_mplier <= SUM_W'(r_count);
            r_root   <= '0;
            r_srem   <= '0;
            r_drem   <= '0;
        end
        if (i_cmd.load_b) begin
            r_mcand  <= D_W'(r_sum);
            r_mplier <= r_sum;
        end
        if (i_cmd.step_a || i_cmd.step_b) begin
            if (r_mplier[0]) begin
                r_acc <= i_cmd.step_a ? r_acc + r_mcand : r_acc - r_mcand;
            end
            r_mcand  <= {r_mcand[D_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[SUM_W-1:1]};
        end
        if (i_cmd.step_sqrt) begin
            r_srem <= sq_take ? (R_W + 2)'(rem_sh - trial) : (R_W + 2)'(rem_sh);
            r_root <= {r_root[R_W-2:0], sq_take};
            r_acc  <= {r_acc[D_W-3:0], 2'b00};
        end
        if (i_cmd.step_div) begin
            r_drem <= div_take ? CNT_W'(div_sh - div_n) : div_sh[CNT_W-1:0];
            r_root <= {r_root[R_W-2:0], div_take};
        end
        if (i_cmd.emit) r_out_data <= r_root[RMS_W-1:0];
    end

    assign o_out_valid = r_out_valid;
    assign o_rms_value = r_out_data;

endmodule

[rtl/windowed_ac_rms.sv]
// Windowed RMS with mean removal: takes one ADC sample per transfer and, when
// the window closes, returns floor(isqrt(N*sum_sq - sum^2) / N). A sample that
// does not close a window is accumulated in the idle state. The closing sample
// starts a sequence in which a one-bit-per-cycle shift-add multiplier forms
// both products, then the square root and the division each take one digit
// per cycle. No sample is taken during that sequence; the result register lets
// a pending result wait while the next window fills. Window lengths of 0 and 1
// act as 2 and lengths above MAX_WINDOW act as MAX_WINDOW. Depends on war_pkg,
// war_ctrl and war_dp.
module windowed_ac_rms
    import war_pkg::*;
#(
    parameter int MAX_WINDOW  = 8192,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wen,
    input  logic [WINDOW_REG_W-1:0] i_cfg_wdata,    // window_length
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [15:0]             i_s_axis_tdata, // [11:0] sample, [15:12] zero
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [15:0]             o_m_axis_tdata  // [11:0] rms_value, [15:12] zero
);

    localparam int SB    = (SAMPLE_BITS < SAMPLE_FIELD_W) ? SAMPLE_BITS : SAMPLE_FIELD_W;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SB + CNT_W;

    t_cmd             cmd;
    t_status          status;
    logic [RMS_W-1:0] rms_value;

    war_ctrl #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    war_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .SB         (SB)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (i_s_axis_tdata[SAMPLE_FIELD_W-1:0]),
        .i_cmd       (cmd),
        .i_out_ready (i_m_axis_tready),
        .o_status    (status),
        .o_out_valid (o_m_axis_tvalid),
        .o_rms_value (rms_value)
    );

    assign o_m_axis_tdata = 16'(rms_value);

endmodule

[rtl/war_checker.sv]
// Port-level checker for windowed_ac_rms, bound to the top level.
// Depends on war_pkg and windowed_ac_rms_macros.svh.
`include "windowed_ac_rms_macros.svh"

module war_checker
    import war_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata  // [11:0] rms_value
);

    // A result that is not taken stays offered unchanged.
    `WAR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // A standard deviation of 12-bit samples never exceeds 2048.
    `WAR_ASSERT_SAME(a_rms_range, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tdata[15:12] == 4'd0) && (o_m_axis_tdata[11:0] <= 12'd2048))

    // A new result appears only at the end of a computation, when no sample is taken.
    `WAR_ASSERT_SAME(a_emit_busy, i_clk, i_rst_n, $rose(o_m_axis_tvalid), !$past(o_s_axis_tready))

    // Reset leaves the block ready for samples with no result pending.
    `WAR_ASSERT_NEXT(a_reset_state, i_clk, 1'b1, !i_rst_n, o_s_axis_tready && !o_m_axis_tvalid)

endmodule

bind windowed_ac_rms war_checker u_war_checker (.*);

[sim/windowed_ac_rms_checker.sv]
`timescale 1ns / 100ps
// Checker for windowed_ac_rms: watches the configuration port and both streams,
// predicts every RMS result and compares it with what the block returns.
// Depends on war_pkg.
module windowed_ac_rms_checker
    import war_pkg::*;
#(
    parameter int MAX_WINDOW  = 8192,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wen,
    input  logic [WINDOW_REG_W-1:0] i_cfg_wdata,
    input  logic                    i_s_tvalid,
    input  logic                    i_s_tready,
    input  logic [15:0]             i_s_tdata,   // [11:0] sample, [15:12] zero
    input  logic                    i_m_tvalid,
    input  logic                    i_m_tready,
    input  logic [15:0]             i_m_tdata,   // [11:0] rms_value, [15:12] zero
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef logic [WINDOW_REG_W-1:0] t_window;
    typedef logic [RMS_W-1:0]        t_rms;

    t_window      window_len;
    logic [13:0]  sample_count;
    logic [24:0]  running_sum;
    logic [36:0]  square_sum;
    t_rms         rms_due[$];

    function automatic t_window effective_length(input t_window w);
        if (w < t_window'(MIN_WINDOW)) return t_window'(MIN_WINDOW);
        if (w > t_window'(MAX_WINDOW)) return t_window'(MAX_WINDOW);
        return w;
    endfunction

    // Largest root whose square does not exceed x, built one bit at a time.
    function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (32'd1 << i);
            if ({32'd0, trial} * {32'd0, trial} <= x) root = trial;
        end
        return root;
    endfunction

    task automatic take_sample(input logic [SAMPLE_BITS-1:0] s);
        logic [63:0] s_wide;
        logic [63:0] n;
        logic [63:0] total;
        logic [63:0] squares;
        logic [63:0] spread;
        logic [63:0] quotient;
        logic [31:0] root;
        s_wide       = {{(64-SAMPLE_BITS){1'b0}}, s};
        squares      = s_wide * s_wide;
        sample_count = sample_count + 14'd1;
        running_sum  = running_sum + s_wide[24:0];
        square_sum   = square_sum + squares[36:0];
        if (sample_count < effective_length(window_len)) return;

        // The true count is used as N, which matters when the window was shortened.
        n        = {50'd0, sample_count};
        total    = {39'd0, running_sum};
        squares  = {27'd0, square_sum};
        spread   = n * squares - total * total;
        root     = floor_sqrt(spread);
        quotient = {32'd0, root} / n;
        rms_due.push_back(quotient[RMS_W-1:0]);
        sample_count = '0;
        running_sum  = '0;
        square_sum   = '0;
    endtask

    task automatic check_result(input logic [15:0] word);
        t_rms want;
        if (rms_due.size() == 0) begin
            o_fail_count = o_fail_count + 1;
            if (o_fail_count <= 10)
                $display("unexpected rms transfer: tdata %h", word);
            return;
        end
        want = rms_due.pop_front();
        if (word !== {{(16-RMS_W){1'b0}}, want}) begin
            o_fail_count = o_fail_count + 1;
            if (o_fail_count <= 10)
                $display("rms mismatch: expected %0d, got %0d (tdata %h)",
                         want, word[RMS_W-1:0], word);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_len   = WINDOW_RESET;
            sample_count = '0;
            running_sum  = '0;
            square_sum   = '0;
            rms_due.delete();
        end else begin
            if (i_cfg_wen) window_len = i_cfg_wdata;
            // Results are taken before samples so that a new expectation is
            // never matched against an older result in the same cycle.
            if (i_m_tvalid && i_m_tready) check_result(i_m_tdata);
            if (i_s_tvalid && i_s_tready) take_sample(i_s_tdata[SAMPLE_BITS-1:0]);
        end
        o_pending = rms_due.size();
    end

endmodule

[sim/windowed_ac_rms_tb.sv]
`timescale 1ns / 100ps
// Top of the windowed_ac_rms testbench: clock, reset, window writes, sample
// stimulus and the verdict. Depends on war_pkg, windowed_ac_rms and the checker.
module windowed_ac_rms_tb;
    import war_pkg::*;

    localparam int MAX_WINDOW    = 8192;
    localparam int SAMPLE_BITS   = 12;
    localparam int RANDOM_ITEMS  = 420;
    localparam int QUIET_ITEMS   = 80;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 500000;

    typedef logic [WINDOW_REG_W-1:0]   t_window;
    typedef logic [SAMPLE_FIELD_W-1:0] t_sample;
    typedef logic [15:0]               t_word;
    typedef enum logic [1:0] {MIX_RANDOM, MIX_RAILS, MIX_NOISY, MIX_FLAT} t_mix;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    cfg_wen   = 1'b0;
    t_window cfg_wdata = '0;
    logic    s_tvalid  = 1'b0;
    logic    s_tready;
    t_word   s_tdata   = '0;
    logic    m_tvalid;
    logic    m_tready  = 1'b0;
    t_word   m_tdata;
    int      fail_count;
    int      pending;
    bit      idling     = 1'b1;
    int      stall_left = 0;
    int      cycles     = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    windowed_ac_rms #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wen       (cfg_wen),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    windowed_ac_rms_checker #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wen    (cfg_wen),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result back-pressure: random bursts with tready low.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idling && $urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("windowed_ac_rms_tb failed");
            $finish;
        end
    end

    function automatic t_sample pick_sample(input t_mix mix, input t_sample centre);
        logic [31:0] r;
        r = $urandom;
        case (mix)
            MIX_RAILS: return r[0] ? t_sample'('1) : t_sample'(0);
            MIX_NOISY: return centre ^ t_sample'(r[2:0]);
            MIX_FLAT:  return centre;
            default:   return r[SAMPLE_FIELD_W-1:0];
        endcase
    endfunction

    task automatic send_sample(input t_sample value);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t_word'(value);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic set_window(input t_window value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Drops tvalid, waits until every predicted result has been taken, then lets the bench settle.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(inout int sent);
        t_window     w;
        t_sample     centre;
        t_mix        mix;
        logic [31:0] r;
        int          pick;
        int          n;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            w = t_window'($urandom_range(0, 1));
            n = $urandom_range(1, 6);
        end else if (pick <= 2) begin
            w = t_window'($urandom_range(25, 120));
            n = int'(w) + $urandom_range(0, 8);
        end else if (pick == 3) begin
            // A long window left part-filled; a later, shorter length closes it.
            w = t_window'($urandom_range(200, 16383));
            n = $urandom_range(1, 20);
        end else begin
            w = t_window'($urandom_range(2, 16));
            n = $urandom_range(1, 3 * int'(w));
        end
        mix    = t_mix'($urandom_range(0, 3));
        r      = $urandom;
        centre = r[SAMPLE_FIELD_W-1:0];
        set_window(w);
        repeat (n) send_sample(pick_sample(mix, centre));
        sent = sent + n;
        settle();
    endtask

    initial begin : stimulus
        int random_sent;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lengths below two act as two.
        set_window(t_window'(0));
        send_sample(12'h000);
        send_sample(12'hFFF);
        send_sample(12'hFFF);
        send_sample(12'hFFF);
        settle();
        set_window(t_window'(1));
        send_sample(12'hAAA);
        send_sample(12'h555);
        settle();
        set_window(t_window'(3));
        send_sample(12'hFFF);
        send_sample(12'h000);
        send_sample(12'h001);
        settle();

        // Window shortened below the count already taken.
        set_window(t_window'(10));
        repeat (5) send_sample(pick_sample(MIX_RANDOM, '0));
        settle();
        set_window(t_window'(3));
        send_sample(12'h800);
        settle();

        // Maximum length, then shortened to exactly the count already taken.
        set_window(t_window'(MAX_WINDOW));
        repeat (5) send_sample(pick_sample(MIX_RANDOM, '0));
        settle();
        set_window(t_window'(5));
        send_sample(pick_sample(MIX_RANDOM, '0));
        settle();

        // Just above the maximum, then shortened to the minimum.
        set_window(t_window'(MAX_WINDOW + 1));
        repeat (3) send_sample(pick_sample(MIX_RANDOM, '0));
        settle();
        set_window(t_window'(2));
        send_sample(pick_sample(MIX_RANDOM, '0));
        settle();

        // One full window of rail-to-rail samples pushes the spread toward its top.
        set_window(t_window'(64));
        repeat (64) send_sample(pick_sample(MIX_RAILS, '0));
        settle();

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            idling = (random_sent < RANDOM_ITEMS - QUIET_ITEMS);
            random_phase(random_sent);
        end
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("windowed_ac_rms_tb passed");
        end else begin
            $display("windowed_ac_rms_tb failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/war_pkg.sv
rtl/war_ctrl.sv
rtl/war_dp.sv
rtl/windowed_ac_rms.sv
rtl/war_checker.sv
sim/windowed_ac_rms_checker.sv
sim/windowed_ac_rms_tb.sv
